FILE: hdl/lip_pkg.sv
// ----------------------------------------------------------------------------
// lip_pkg: shared types and constants for the patience-sorting LIS block
// Holds the fixed result width and the status word that each tail cell
// reports to the control logic.
// ----------------------------------------------------------------------------
package lip_pkg;

    // Width of the length field in a result word.
    localparam int LEN_BITS = 11;

    // Status that a tail cell reports for the key under test.
    typedef struct packed {
        logic ge;    // cell is empty or its tail is not below the key
        logic take;  // cell is the first empty one and receives the key
    } lip_cell_stat_t;

endpackage

FILE: hdl/lip_cell.sv
// ----------------------------------------------------------------------------
// lip_cell: one tail cell of the patience-sorting row
// Holds one tail, compares it against the broadcast key and, together with
// the verdict of its left neighbor, decides whether it takes the key.
// ----------------------------------------------------------------------------
module lip_cell
    import lip_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int CNT_BITS   = 11,
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         fire,
    input  logic        [CNT_BITS-1:0]   count,
    input  logic signed [VALUE_BITS-1:0] key,
    input  logic                         prev_ge,
    output lip_cell_stat_t               stat
);

    logic signed [VALUE_BITS-1:0] tail_reg;
    logic signed [VALUE_BITS-1:0] tail_next;
    logic                         in_use;
    logic                         ge;
    logic                         chosen;

    // A cell holds a live tail when its position lies below the tail count.
    assign in_use = (CNT_BITS'(IDX) < count);

    // Live tails are sorted, so the first cell that is not below the key is
    // the lower bound; an empty cell counts as not below any key.
    assign ge     = !in_use || (tail_reg >= key);
    assign chosen = ge && !prev_ge;

    assign stat.ge   = ge;
    assign stat.take = chosen && !in_use;

    // The chosen cell replaces its tail, or takes the key as a new tail.
    always_comb
    begin
        tail_next = tail_reg;
        if (fire && chosen)
        begin
            tail_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
    end

endmodule

FILE: hdl/lis_length_patience.sv
// ----------------------------------------------------------------------------
// lis_length_patience: streaming longest strictly increasing subsequence
// Keeps the patience-sorting tail store in a row of cells and returns the
// current subsequence length for every input word.
// ----------------------------------------------------------------------------
// Each input word gives exactly one result word: the word waits in the input
// register, then its result is loaded into the result register. While the
// word sits in the input register, its key is compared against every cell of
// the tail row at once. On the edge on which the word fires, the lower-bound
// cell takes the key and the result register loads. A result word that is
// not drained holds the input register and stalls the input. The row accepts
// a new word every cycle as long as results are drained, so the sustained
// rate is one word per cycle; that figure is set by the single parallel
// compare across the MAX_LEN cells. A word greater than every tail while the
// row is full is dropped and flagged with overflow. A word marked last ends
// the sequence: its result carries done_res and the length is cleared for
// the next word. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module lis_length_patience
    import lip_pkg::*;
#(
    parameter int MAX_LEN    = 1024,
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         last,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic        [LEN_BITS-1:0]   length,
    output logic                         overflow,
    output logic                         done_res
);

    localparam int CNT_BITS = $clog2(MAX_LEN + 1);

    // Input register.
    logic                         hold_valid_reg;
    logic                         hold_valid_next;
    logic signed [VALUE_BITS-1:0] hold_value_reg;
    logic                         hold_last_reg;

    // Tail count.
    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          count_next;
    logic [CNT_BITS-1:0]          count_sum;

    // Result register.
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic [LEN_BITS-1:0]          res_length_reg;
    logic                         res_overflow_reg;
    logic                         res_done_reg;

    logic                         res_free;
    logic                         fire;
    logic                         take_in;
    logic                         append;
    logic                         full_drop;

    lip_cell_stat_t               stat [MAX_LEN];
    logic [MAX_LEN-1:0]           take_vec;

    // Handshake: the held word is processed when the result slot is free.
    assign res_free   = !res_valid_reg || !res_stall;
    assign fire       = hold_valid_reg && res_free;
    assign item_stall = hold_valid_reg && !res_free;
    assign take_in    = item_valid && !item_stall;

    // Row of tail cells; each cell hears the verdict of its left neighbor.
    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        logic prev_ge;

        if (k == 0)
        begin : g_first
            assign prev_ge = 1'b0;
        end
        else
        begin : g_rest
            assign prev_ge = stat[k-1].ge;
        end

        lip_cell #(
            .IDX        (k),
            .CNT_BITS   (CNT_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk     (clk),
            .fire    (fire),
            .count   (count_reg),
            .key     (hold_value_reg),
            .prev_ge (prev_ge),
            .stat    (stat[k])
        );

        assign take_vec[k] = stat[k].take;
    end

    // The key grows the store when the first empty cell takes it; when even
    // the last cell is below the key, the row is full and the word is dropped.
    assign append    = |take_vec;
    assign full_drop = !stat[MAX_LEN-1].ge;
    assign count_sum = count_reg + CNT_BITS'(append);

    // Next-state logic for the count and the two valid flags.
    always_comb
    begin
        count_next      = count_reg;
        hold_valid_next = hold_valid_reg;
        res_valid_next  = res_valid_reg;
        if (fire)
        begin
            count_next = hold_last_reg ? '0 : count_sum;
        end
        if (take_in)
        begin
            hold_valid_next = 1'b1;
        end
        else if (fire)
        begin
            hold_valid_next = 1'b0;
        end
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
            count_reg      <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            hold_value_reg <= value;
            hold_last_reg  <= last;
        end
        if (fire)
        begin
            res_length_reg   <= LEN_BITS'(count_sum);
            res_overflow_reg <= full_drop;
            res_done_reg     <= hold_last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign length    = res_length_reg;
    assign overflow  = res_overflow_reg;
    assign done_res  = res_done_reg;

endmodule

FILE: tb/lis_length_patience_tb.sv
// ----------------------------------------------------------------------------
// lis_length_patience_tb: self-checking bench for the streaming LIS block
// Drives signed words through the valid/stall input channel and keeps a
// patience-sorting model of the tail store. Every result word is checked against
// the model, or the table on chk rows. Stimulus covers a directed table, random
// sequences of several shapes, and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lis_length_patience_tb
    import lip_pkg::*;
;

    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int DIR_ROWS   = 23;
    localparam int RAND_WORDS = 490;
    localparam int HOLD_CYCLES = 60;

    // One expected result word.
    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        logic                ovf;
        logic                done;
    } res_word_t;

    // One row of the directed table. The expected fields count only when chk is set.
    typedef struct packed {
        logic [VALUE_BITS-1:0] val;
        logic                  fin;
        logic                  chk;
        logic [LEN_BITS-1:0]   len;
        logic                  ovf;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_stall;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
    logic                         res_valid;
    logic                         res_stall;
    logic        [LEN_BITS-1:0]   length;
    logic                         overflow;
    logic                         done_res;

    // Side information that travels with the word being offered.
    logic                drv_chk;
    logic [LEN_BITS-1:0] drv_len;
    logic                drv_ovf;

    logic signed [VALUE_BITS-1:0] tail_mem [MAX_LEN];
    int                           tail_cnt;
    res_word_t                    lis_len_q [$];
    int                           err_cnt;
    bit                           tx_idle_on;
    bit                           rx_idle_on;
    int                           hold_req_cnt;
    int                           hold_done_cnt;
    dir_row_t                     dir_tab [DIR_ROWS];

    lis_length_patience #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .last       (last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .length     (length),
        .overflow   (overflow),
        .done_res   (done_res)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard limit on the run.
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // Patience-sorting step: updates the tail store and returns the result word.
    function automatic void patience_step(input logic signed [VALUE_BITS-1:0] v,
                                          input logic fin, output res_word_t r);
        int lo;
        int hi;
        int mid;
        r.ovf = 1'b0;
        if (tail_cnt == 0 || tail_mem[tail_cnt - 1] < v)
        begin
            if (tail_cnt < MAX_LEN)
            begin
                tail_mem[tail_cnt] = v;
                tail_cnt++;
            end
            else
            begin
                r.ovf = 1'b1;
            end
        end
        else
        begin
            // Lower bound: first tail that is not below the value.
            lo = 0;
            hi = tail_cnt;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (tail_mem[mid] < v)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            tail_mem[lo] = v;
        end
        r.len  = LEN_BITS'(tail_cnt);
        r.done = fin;
        if (fin)
            tail_cnt = 0;
    endfunction

    // Monitor: predicts on each accepted input word and checks each accepted result.
    always @(posedge clk)
    begin : mon
        res_word_t pred;
        res_word_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                patience_step(value, last, pred);
                if (drv_chk)
                begin
                    pred.len = drv_len;
                    pred.ovf = drv_ovf;
                end
                lis_len_q = {lis_len_q, pred};
            end
            if (res_valid === 1'b1 && res_stall == 1'b0)
            begin
                if (lis_len_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: length %0d", $realtime,
                             length);
                    err_cnt++;
                end
                else
                begin
                    want = lis_len_q.pop_front();
                    if (length !== want.len)
                    begin
                        $display("%0t: length expected %0d actual %0d", $realtime, want.len,
                                 length);
                        err_cnt++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $display("%0t: overflow expected %0b actual %0b", $realtime, want.ovf,
                                 overflow);
                        err_cnt++;
                    end
                    if (done_res !== want.done)
                    begin
                        $display("%0t: done_res expected %0b actual %0b", $realtime, want.done,
                                 done_res);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req_cnt != hold_done_cnt)
            begin
                res_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done_cnt++;
                res_stall = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                res_stall = 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                res_stall = 1'b0;
            end
            else
            begin
                res_stall = 1'b0;
            end
        end
    end

    // Offer one word and wait until it is taken.
    task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic fin,
                             input logic chk, input logic [LEN_BITS-1:0] len,
                             input logic ovf);
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        value      = v;
        last       = fin;
        drv_chk    = chk;
        drv_len    = len;
        drv_ovf    = ovf;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // One random sequence of n words in a given shape; the final word carries last.
    task automatic send_seq(input int n, input int shape);
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] base;
        base = $urandom();
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                0: v = $urandom();
                1: v = VALUE_BITS'($urandom_range(0, 15) - 8);
                2:
                begin
                    base = base + VALUE_BITS'($urandom_range(0, 1000) - 100);
                    v    = base;
                end
                default:
                begin
                    base = base - VALUE_BITS'($urandom_range(0, 50));
                    v    = base;
                end
            endcase
            send_word(v, i == n - 1, 1'b0, '0, 1'b0);
        end
    endtask

    // Main sequence.
    initial
    begin : main
        int sent;
        int n;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        value         = '0;
        last          = 1'b0;
        drv_chk       = 1'b0;
        drv_len       = '0;
        drv_ovf       = 1'b0;
        tail_cnt      = 0;
        err_cnt       = 0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        hold_req_cnt  = 0;
        hold_done_cnt = 0;

        // Directed table: extremes, equal values, lower-bound replaces, clears.
        dir_tab = '{
            '{32'h0000_0000, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h8000_0000, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h7fff_ffff, 1'b0, 1'b1, 11'd2, 1'b0},
            '{32'h7fff_ffff, 1'b0, 1'b1, 11'd2, 1'b0},
            '{32'hffff_ffff, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'h0000_0005, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'h0000_0003, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'h0000_0003, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'h0000_0064, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'h8000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'h0000_0004, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'h7fff_ffff, 1'b1, 1'b0, 11'd0, 1'b0},
            '{32'h0000_002a, 1'b1, 1'b1, 11'd1, 1'b0},
            '{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
            '{32'h7fff_ffff, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h0000_000a, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h0000_0009, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h0000_0008, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h0000_0007, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h0000_0006, 1'b1, 1'b1, 11'd1, 1'b0},
            '{32'h0000_0001, 1'b0, 1'b1, 11'd1, 1'b0},
            '{32'h0000_0002, 1'b0, 1'b1, 11'd2, 1'b0},
            '{32'h0000_0003, 1'b1, 1'b1, 11'd3, 1'b0}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i].val, dir_tab[i].fin, dir_tab[i].chk, dir_tab[i].len,
                      dir_tab[i].ovf);

        // Random sequences with idling on both sides.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        sent = 0;
        while (sent < RAND_WORDS / 3)
        begin
            n = $urandom_range(1, 40);
            send_seq(n, $urandom_range(0, 3));
            sent += n;
        end

        // Long receiver hold-off while the sender keeps offering words.
        tx_idle_on = 1'b0;
        hold_req_cnt++;
        send_seq(30, 0);
        tx_idle_on = 1'b1;

        while (sent < RAND_WORDS)
        begin
            // The closing stretch runs with no idling at all.
            if (sent > RAND_WORDS - 70)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            n = $urandom_range(1, 40);
            send_seq(n, $urandom_range(0, 3));
            sent += n;
        end

        @(negedge clk);
        item_valid = 1'b0;

        while (lis_len_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_cnt == 0 && lis_len_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/lip_pkg.sv
hdl/lip_cell.sv
hdl/lis_length_patience.sv
tb/lis_length_patience_tb.sv
